// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ettc_pkg.sv =====
// Types, constants and codes of the equivalent-time trigger capture block
package ettc_pkg;

   localparam int unsigned BUFFER_DEPTH = 512;
   localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int unsigned INDEX_W      = ADDR_W + 1;

   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned REQ_W     = 3;
   localparam int unsigned RIDX_W    = 9;
   localparam int unsigned CIDX_W    = 9;
   localparam int unsigned LEVEL_W   = 12;
   localparam int unsigned STEP_W    = 16;
   localparam int unsigned TIMEOUT_W = 24;
   localparam int unsigned DELAY_W   = ADDR_W + STEP_W;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [LEVEL_W-1:0]   LEVEL_RESET   = 12'd2048;
   localparam logic                 RISING_RESET  = 1'b1;
   localparam logic [STEP_W-1:0]    STEP_RESET    = 16'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd168000;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK  = 3'd0,
      REQ_START = 3'd1,
      REQ_STOP  = 3'd2,
      REQ_CLEAR = 3'd3,
      REQ_READ  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      PH_ARM   = 2'd0,
      PH_WAIT  = 2'd1,
      PH_DELAY = 2'd2
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEVEL   = 2'd0,
      CSR_RISING  = 2'd1,
      CSR_STEP    = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   trigger_level;
      logic                 rising_edge;
      logic [STEP_W-1:0]    delay_step_ticks;
      logic [TIMEOUT_W-1:0] trigger_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [SAMPLE_W-1:0] sample_value;
      logic [RIDX_W-1:0]   read_index;
   } req_item_type;

   typedef struct packed {
      logic                running;
      logic                buffer_ready;
      logic                captured;
      logic [CIDX_W-1:0]   capture_index;
      logic                capture_triggered;
      logic [SAMPLE_W-1:0] read_data;
   } rsp_item_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } mem_wr_type;

endpackage

// ===== design/ettc_ram.sv =====
// Sample buffer: one write port, one registered read port with write bypass
module ettc_ram #(
   parameter int unsigned DEPTH = 512,
   parameter int unsigned WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // a word written in the same cycle is passed straight through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ettc_csr.sv =====
// Configuration registers of the trigger capture block
module ettc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ettc_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [ettc_pkg::CSR_DATA_W-1:0]  csr_data,
   output ettc_pkg::cfg_type                cfg
);

   ettc_pkg::cfg_type cfg_ff;
   ettc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ettc_pkg::csr_reg_type'(csr_index))
            ettc_pkg::CSR_LEVEL:
               cfg_in.trigger_level = csr_data[ettc_pkg::LEVEL_W-1:0];
            ettc_pkg::CSR_RISING:
               cfg_in.rising_edge = csr_data[0];
            ettc_pkg::CSR_STEP:
               cfg_in.delay_step_ticks = csr_data[ettc_pkg::STEP_W-1:0];
            ettc_pkg::CSR_TIMEOUT:
               cfg_in.trigger_timeout_ticks = csr_data[ettc_pkg::TIMEOUT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level         <= ettc_pkg::LEVEL_RESET;
         cfg_ff.rising_edge           <= ettc_pkg::RISING_RESET;
         cfg_ff.delay_step_ticks      <= ettc_pkg::STEP_RESET;
         cfg_ff.trigger_timeout_ticks <= ettc_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ===== design/ettc_core.sv =====
// Acquisition state and per-word update: arm, trigger wait, delay, store
module ettc_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               commit,
   input  ettc_pkg::req_item_type             item,
   input  logic [ettc_pkg::SAMPLE_W-1:0]      rd_data,
   input  ettc_pkg::cfg_type                  cfg,
   output ettc_pkg::rsp_item_type             result,
   output ettc_pkg::mem_wr_type               mem_wr
);

   ettc_pkg::phase_type                 phase_ff, phase_in;
   logic [ettc_pkg::SAMPLE_W-1:0]       prev_ff, prev_in;
   logic [ettc_pkg::TIMEOUT_W-1:0]      timeout_ff, timeout_in;
   logic [ettc_pkg::DELAY_W-1:0]        delay_ff, delay_in;
   logic [ettc_pkg::INDEX_W-1:0]        widx_ff, widx_in;
   logic                                ready_ff, ready_in;
   logic                                run_ff, run_in;

   logic                                is_tick;
   logic                                tick_active;
   logic                                hit;
   logic [ettc_pkg::TIMEOUT_W-1:0]      timeout_inc;
   logic                                timed_out;
   logic                                store;
   logic                                room;
   logic [ettc_pkg::INDEX_W-1:0]        widx_inc;
   logic                                read_in_range;
   logic [ettc_pkg::SAMPLE_W-1:0]       cur;

   assign cur         = item.sample_value;
   assign is_tick     = (item.req_type == ettc_pkg::REQ_TICK);
   assign tick_active = commit && is_tick && run_ff && !ready_ff;

   assign hit = cfg.rising_edge
              ? ((prev_ff < cfg.trigger_level) && (cur >= cfg.trigger_level))
              : ((prev_ff > cfg.trigger_level) && (cur <= cfg.trigger_level));

   // count wraps; a zero timeout acts as one
   assign timeout_inc = timeout_ff + 1'b1;
   assign timed_out   = (timeout_inc >= cfg.trigger_timeout_ticks) || (timeout_inc == '0);

   assign store = tick_active
                && (((phase_ff == ettc_pkg::PH_WAIT) && !hit && timed_out)
                 || ((phase_ff == ettc_pkg::PH_DELAY) && (delay_ff == '0)));

   assign room          = (widx_ff < ettc_pkg::INDEX_W'(ettc_pkg::BUFFER_DEPTH));
   assign widx_inc      = widx_ff + 1'b1;
   assign read_in_range = (32'(item.read_index) < ettc_pkg::BUFFER_DEPTH);

   // phase transitions
   always_comb begin
      phase_in = phase_ff;
      if (commit) begin
         unique case (item.req_type)
            ettc_pkg::REQ_TICK: begin
               if (tick_active) begin
                  unique case (phase_ff)
                     ettc_pkg::PH_ARM:   phase_in = ettc_pkg::PH_WAIT;
                     ettc_pkg::PH_WAIT: begin
                        if (hit) begin
                           phase_in = ettc_pkg::PH_DELAY;
                        end else if (store) begin
                           phase_in = ettc_pkg::PH_ARM;
                        end
                     end
                     ettc_pkg::PH_DELAY: begin
                        if (store) begin
                           phase_in = ettc_pkg::PH_ARM;
                        end
                     end
                     default: phase_in = ettc_pkg::PH_ARM;
                  endcase
               end
            end
            ettc_pkg::REQ_START,
            ettc_pkg::REQ_STOP,
            ettc_pkg::REQ_CLEAR: phase_in = ettc_pkg::PH_ARM;
            default: phase_in = phase_ff;
         endcase
      end
   end

   // data state, buffer write and result word
   always_comb begin
      prev_in    = prev_ff;
      timeout_in = timeout_ff;
      delay_in   = delay_ff;
      widx_in    = widx_ff;
      ready_in   = ready_ff;
      run_in     = run_ff;

      mem_wr.en   = 1'b0;
      mem_wr.addr = widx_ff[ettc_pkg::ADDR_W-1:0];
      mem_wr.data = cur;

      result.captured          = 1'b0;
      result.capture_index     = '0;
      result.capture_triggered = 1'b0;
      result.read_data         = '0;

      if (commit) begin
         unique case (item.req_type)
            ettc_pkg::REQ_TICK: begin
               if (tick_active) begin
                  unique case (phase_ff)
                     ettc_pkg::PH_ARM: begin
                        prev_in    = cur;
                        timeout_in = '0;
                     end
                     ettc_pkg::PH_WAIT: begin
                        if (hit) begin
                           delay_in = ettc_pkg::DELAY_W'(
                              widx_ff[ettc_pkg::ADDR_W-1:0] * cfg.delay_step_ticks);
                        end else begin
                           prev_in    = cur;
                           timeout_in = timeout_inc;
                        end
                     end
                     ettc_pkg::PH_DELAY: begin
                        if (delay_ff != '0) begin
                           delay_in = delay_ff - 1'b1;
                        end
                     end
                     default: prev_in = prev_ff;
                  endcase
                  if (store) begin
                     if (room) begin
                        mem_wr.en                = 1'b1;
                        result.captured          = 1'b1;
                        result.capture_index     = ettc_pkg::CIDX_W'(widx_ff);
                        result.capture_triggered = (phase_ff == ettc_pkg::PH_DELAY);
                        widx_in                  = widx_inc;
                        if (widx_inc >= ettc_pkg::INDEX_W'(ettc_pkg::BUFFER_DEPTH)) begin
                           ready_in = 1'b1;
                        end
                     end else begin
                        ready_in = 1'b1;
                     end
                  end
               end
            end
            ettc_pkg::REQ_START: begin
               widx_in  = '0;
               ready_in = 1'b0;
               run_in   = 1'b1;
            end
            ettc_pkg::REQ_STOP: begin
               run_in = 1'b0;
            end
            ettc_pkg::REQ_CLEAR: begin
               ready_in = 1'b0;
               widx_in  = '0;
            end
            ettc_pkg::REQ_READ: begin
               if (read_in_range) begin
                  result.read_data = rd_data;
               end
            end
            default: run_in = run_ff;
         endcase
      end

      result.running      = run_in;
      result.buffer_ready = ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ettc_pkg::PH_ARM;
         prev_ff    <= '0;
         timeout_ff <= '0;
         delay_ff   <= '0;
         widx_ff    <= '0;
         ready_ff   <= 1'b0;
         run_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         prev_ff    <= prev_in;
         timeout_ff <= timeout_in;
         delay_ff   <= delay_in;
         widx_ff    <= widx_in;
         ready_ff   <= ready_in;
         run_ff     <= run_in;
      end
   end

endmodule

// ===== design/equivalent_time_trigger_capture.sv =====
// Top level of the equivalent-time trigger capture block
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type, sample_value, read_index
//   rsp_      out        rsp_valid/rsp_stall  status, capture and read_data fields
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// One word per cycle unless the result stalls: an accepted word is held in the
// input register, updated against the acquisition state and buffer, and then
// registered in the output register. The buffer read is started at acceptance.
// Reset is synchronous; the buffer contents are not cleared. A stalled result
// holds the input register, which then stalls the request side.
module equivalent_time_trigger_capture (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ettc_pkg::REQ_W-1:0]       req_type,
   input  logic [ettc_pkg::SAMPLE_W-1:0]    req_sample_value,
   input  logic [ettc_pkg::RIDX_W-1:0]      req_read_index,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_running,
   output logic                             rsp_buffer_ready,
   output logic                             rsp_captured,
   output logic [ettc_pkg::CIDX_W-1:0]      rsp_capture_index,
   output logic                             rsp_capture_triggered,
   output logic [ettc_pkg::SAMPLE_W-1:0]    rsp_read_data,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ettc_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [ettc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                          in_valid_ff, in_valid_in;
   ettc_pkg::req_item_type        item_ff;
   logic                          out_valid_ff, out_valid_in;
   ettc_pkg::rsp_item_type        rsp_ff;

   logic                          accept;
   logic                          advance;
   ettc_pkg::cfg_type             cfg;
   ettc_pkg::rsp_item_type        result;
   ettc_pkg::mem_wr_type          mem_wr;
   logic [ettc_pkg::SAMPLE_W-1:0] rd_data;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.req_type     <= req_type;
         item_ff.sample_value <= req_sample_value;
         item_ff.read_index   <= req_read_index;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   ettc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ettc_ram #(
      .DEPTH (ettc_pkg::BUFFER_DEPTH),
      .WIDTH (ettc_pkg::SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (accept),
      .rd_addr (ettc_pkg::ADDR_W'(req_read_index)),
      .rd_data (rd_data)
   );

   ettc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .commit  (advance),
      .item    (item_ff),
      .rd_data (rd_data),
      .cfg     (cfg),
      .result  (result),
      .mem_wr  (mem_wr)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_running           = rsp_ff.running;
   assign rsp_buffer_ready      = rsp_ff.buffer_ready;
   assign rsp_captured          = rsp_ff.captured;
   assign rsp_capture_index     = rsp_ff.capture_index;
   assign rsp_capture_triggered = rsp_ff.capture_triggered;
   assign rsp_read_data         = rsp_ff.read_data;

endmodule

// ===== design/ettc_checker.sv =====
// Port-level checks of the trigger capture block and their binding
`include "assert_macros.svh"

module ettc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_running,
   input logic                          rsp_captured,
   input logic [ettc_pkg::CIDX_W-1:0]   rsp_capture_index,
   input logic                          rsp_capture_triggered,
   input logic [ettc_pkg::SAMPLE_W-1:0] rsp_read_data
);

   // request side only backs up behind a stalled result
   `ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without result stall")

   `ASSERT_IMPL(a_capture_running, clock, reset, rsp_valid && rsp_captured, rsp_running, "capture while not running")

   `ASSERT_IMPL(a_capture_no_read, clock, reset, rsp_valid && rsp_captured, rsp_read_data == '0, "capture word carries read data")

   `ASSERT_IMPL(a_idle_fields, clock, reset, rsp_valid && !rsp_captured, (rsp_capture_index == '0) && !rsp_capture_triggered, "capture fields set without capture")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_capture_index) && $stable(rsp_read_data), "stalled result changed")

endmodule

bind equivalent_time_trigger_capture ettc_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_running           (rsp_running),
   .rsp_captured          (rsp_captured),
   .rsp_capture_index     (rsp_capture_index),
   .rsp_capture_triggered (rsp_capture_triggered),
   .rsp_read_data         (rsp_read_data)
);
